// ----- rtl/core/rsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared widths, reset values, register indexes and control types for the
// relief shading pipeline.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int HW   = 16;  // height
  localparam int CW   = 8;   // color channel
  localparam int DW   = 18;  // signed relief delta
  localparam int AW   = 17;  // delta magnitude
  localparam int PW   = 25;  // |delta| * light
  localparam int MPW  = 33;  // channel weight * product
  localparam int CDW  = 26;  // channel * denominator
  localparam int QW   = 10;  // quotient by 65535
  localparam int D3W  = 20;  // quotient times third reciprocal
  localparam int D3SH = 11;

  localparam logic [HW-1:0]   OCEAN_RST = 16'd19660;
  localparam logic [CW-1:0]   LIGHT_RST = 8'd75;
  localparam logic [3*CW-1:0] WATER_RST = 24'd620715;

  localparam logic [HW:0]     DEN_BASE  = 17'd65535;
  localparam logic [D3W-1:0]  DIV3_MUL  = 20'd683;
  localparam logic [CW-1:0]   CHAN_MAX  = 8'd255;

  typedef enum logic [1:0] {
    REG_OCEAN = 2'd0,
    REG_LIGHT = 2'd1,
    REG_WATER = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic missing;
    logic div3;     // center below ocean level
    logic neg;      // delta below zero
  } px_ctrl_t;

endpackage

// ----- rtl/core/rsp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rsp_cfg_regs
// Configuration register file: ocean level, light level, water color.
// ----------------------------------------------------------------------------
module rsp_cfg_regs import rsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3*CW-1:0]   cfg_wdata,
  output logic [HW-1:0]     ocean_level,
  output logic [CW-1:0]     light_gain,
  output logic [3*CW-1:0]   water_color
);

  logic [HW-1:0]   ocean_r;
  logic [CW-1:0]   light_r;
  logic [3*CW-1:0] water_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocean_r <= OCEAN_RST;
      light_r <= LIGHT_RST;
      water_r <= WATER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OCEAN: ocean_r <= cfg_wdata[HW-1:0];
        REG_LIGHT: light_r <= cfg_wdata[CW-1:0];
        REG_WATER: water_r <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign ocean_level = ocean_r;
  assign light_gain  = light_r;
  assign water_color = water_r;

endmodule

// ----- rtl/core/rsp_front.sv -----
// ----------------------------------------------------------------------------
// rsp_front
// Stages 1-2: color select, relief delta and its magnitude, then the
// light-scaled relief product shared by all three channels.
// ----------------------------------------------------------------------------
module rsp_front import rsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [HW-1:0]        center_height,
  input  logic [HW-1:0]        east_height,
  input  logic [HW-1:0]        lower_height,
  input  logic                 neighbor_missing,
  input  logic                 is_water,
  input  logic [CW-1:0]        base_red,
  input  logic [CW-1:0]        base_green,
  input  logic [CW-1:0]        base_blue,
  input  logic [HW-1:0]        ocean_level,
  input  logic [CW-1:0]        light_gain,
  input  logic [3*CW-1:0]      water_color,
  output px_ctrl_t             ctrl,
  output logic [PW-1:0]        prod,
  output logic [2:0][CW-1:0]   col
);

  px_ctrl_t             ctrl1_r, ctrl1_nxt, ctrl2_r;
  logic [AW-1:0]        absd1_r, absd1_nxt;
  logic [2:0][CW-1:0]   col1_r, col1_nxt, col2_r;
  logic [PW-1:0]        prod2_r, prod2_nxt;
  logic [DW-1:0]        delta, delta_neg;

  always_comb begin
    delta     = {2'b00, east_height} + {2'b00, lower_height} - {1'b0, center_height, 1'b0};
    delta_neg = '0 - delta;
    ctrl1_nxt.valid   = acc;
    ctrl1_nxt.missing = neighbor_missing;
    ctrl1_nxt.div3    = (center_height < ocean_level);
    ctrl1_nxt.neg     = delta[DW-1];
    absd1_nxt = delta[DW-1] ? delta_neg[AW-1:0] : delta[AW-1:0];
    if (is_water) begin
      col1_nxt = water_color;
    end else begin
      col1_nxt = {base_red, base_green, base_blue};
    end
    prod2_nxt = PW'(absd1_r) * PW'(light_gain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r <= '0;
      ctrl2_r <= '0;
    end else begin
      ctrl1_r <= ctrl1_nxt;
      ctrl2_r <= ctrl1_r;
    end
  end

  always_ff @(posedge clk) begin
    absd1_r <= absd1_nxt;
    col1_r  <= col1_nxt;
    prod2_r <= prod2_nxt;
    col2_r  <= col1_r;
  end

  assign ctrl = ctrl2_r;
  assign prod = prod2_r;
  assign col  = col2_r;

endmodule

// ----- rtl/core/rsp_chan.sv -----
// ----------------------------------------------------------------------------
// rsp_chan
// Stages 3-6 for one color channel: numerator terms, clipped difference,
// quotient by 65535, optional divide by three and saturation.
// ----------------------------------------------------------------------------
module rsp_chan import rsp_pkg::*; (
  input  logic            clk,
  input  logic [CW-1:0]   c,
  input  logic [PW-1:0]   prod,
  input  logic            neg,
  input  logic            div3,
  input  logic            missing,
  output logic [CW-1:0]   y
);

  // numerator = c*D - m*|prod|, m = c for rising relief, 255-c for falling
  logic [CW-1:0]   m;
  logic [3*CW-1:0] c65k;
  logic [MPW-1:0]  mp3_r, mp3_nxt, diff;
  logic [CDW-1:0]  cd3_r, cd3_nxt, x4_r, x4_nxt;
  logic [CW-1:0]   c3_r, c4_r, c5_r, y6_r, y6_nxt;
  logic            d3_3_r, d3_4_r, d3_5_r;
  logic            ms3_r, ms4_r, ms5_r;
  logic [QW-1:0]   q0, q5_r, q5_nxt, qv;
  logic [HW:0]     rem;
  logic [D3W-1:0]  t3;

  always_comb begin
    m       = neg ? (CHAN_MAX - c) : c;
    mp3_nxt = MPW'(m) * MPW'(prod);
    c65k    = {c, 16'h0000} - {16'h0000, c};
    cd3_nxt = div3 ? (CDW'({c65k, 1'b0}) + CDW'(c65k)) : CDW'(c65k);

    diff   = MPW'(cd3_r) - mp3_r;
    x4_nxt = (MPW'(cd3_r) > mp3_r) ? diff[CDW-1:0] : '0;

    // x / 65535: x>>16 is low by at most one; fix with the remainder
    q0     = x4_r[CDW-1:HW];
    rem    = {1'b0, x4_r[HW-1:0]} + (HW+1)'(q0);
    q5_nxt = q0 + QW'(rem >= DEN_BASE);

    t3 = D3W'(q5_r) * DIV3_MUL;
    qv = d3_5_r ? QW'(t3[D3W-1:D3SH]) : q5_r;
    if (ms5_r) begin
      y6_nxt = c5_r;
    end else if (qv > QW'(CHAN_MAX)) begin
      y6_nxt = CHAN_MAX;
    end else begin
      y6_nxt = qv[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mp3_r  <= mp3_nxt;
    cd3_r  <= cd3_nxt;
    c3_r   <= c;
    d3_3_r <= div3;
    ms3_r  <= missing;
    x4_r   <= x4_nxt;
    c4_r   <= c3_r;
    d3_4_r <= d3_3_r;
    ms4_r  <= ms3_r;
    q5_r   <= q5_nxt;
    c5_r   <= c4_r;
    d3_5_r <= d3_4_r;
    ms5_r  <= ms4_r;
    y6_r   <= y6_nxt;
  end

  assign y = y6_r;

endmodule

// ----- rtl/core/relief_shade_pixel.sv -----
// ----------------------------------------------------------------------------
// relief_shade_pixel
// Hill shading of one height-map pixel per clock, six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_* and raise start; a beat is taken at each edge with
//   start high and busy low. busy is high through reset, clears at the first
//   edge that samples rst_n high and then stays low, so one pixel per clock
//   can be streamed with no gaps.
//   Output: out_valid marks out_red/green/blue for exactly one cycle; the
//   sink must take it then, there is no backpressure.
//   Pipeline: a pixel taken at an edge passes six register stages before it
//   shows on the outputs. Throughput: one pixel per clock; the multipliers
//   (light product, channel weight, divide by three) each own a stage.
//   Config: cfg_we with cfg_index 0 ocean level, 1 light level, 2 water
//   color (red in bits 23:16). Write only while no pixel is in flight.
//   Reset (synchronous): registers take their default values, the pipeline
//   valid bits clear, nothing emerges until new pixels are taken.
// ----------------------------------------------------------------------------
module relief_shade_pixel import rsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [HW-1:0]     in_center_height,
  input  logic [HW-1:0]     in_east_height,
  input  logic [HW-1:0]     in_lower_height,
  input  logic              in_neighbor_missing,
  input  logic              in_is_water,
  input  logic [CW-1:0]     in_base_red,
  input  logic [CW-1:0]     in_base_green,
  input  logic [CW-1:0]     in_base_blue,
  output logic              out_valid,
  output logic [CW-1:0]     out_red,
  output logic [CW-1:0]     out_green,
  output logic [CW-1:0]     out_blue,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3*CW-1:0]   cfg_wdata
);

  logic [HW-1:0]       ocean_level;
  logic [CW-1:0]       light_gain;
  logic [3*CW-1:0]     water_color;
  logic                busy_r;
  logic                acc;
  px_ctrl_t            ctrl2;
  logic [PW-1:0]       prod2;
  logic [2:0][CW-1:0]  col2;
  logic [2:0][CW-1:0]  y6;
  logic [3:0]          vld_r, vld_nxt;

  // busy through reset, cleared by the first edge that samples rst_n high
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  assign busy = busy_r;
  assign acc  = start & ~busy_r;

  rsp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .ocean_level (ocean_level),
    .light_gain  (light_gain),
    .water_color (water_color)
  );

  // stages 1-2: color select, delta, |delta| * light
  rsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (acc),
    .center_height    (in_center_height),
    .east_height      (in_east_height),
    .lower_height     (in_lower_height),
    .neighbor_missing (in_neighbor_missing),
    .is_water         (in_is_water),
    .base_red         (in_base_red),
    .base_green       (in_base_green),
    .base_blue        (in_base_blue),
    .ocean_level      (ocean_level),
    .light_gain       (light_gain),
    .water_color      (water_color),
    .ctrl             (ctrl2),
    .prod             (prod2),
    .col              (col2)
  );

  // stages 3-6: one lane per channel; col2[2] is red
  for (genvar i = 0; i < 3; i++) begin : g_chan
    rsp_chan u_chan (
      .clk     (clk),
      .c       (col2[i]),
      .prod    (prod2),
      .neg     (ctrl2.neg),
      .div3    (ctrl2.div3),
      .missing (ctrl2.missing),
      .y       (y6[i])
    );
  end

  // valid bits follow the lanes through stages 3-6
  assign vld_nxt = {vld_r[2:0], ctrl2.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign out_valid = vld_r[3];
  assign out_red   = y6[2];
  assign out_green = y6[1];
  assign out_blue  = y6[0];

endmodule

// ----- sim/relief_shade_pixel_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relief_shade_pixel_tb
// Streams height-map pixels into the shading pipeline with random gaps and
// checks every shaded color against a behavioral predictor of the hillshade
// math. The register settings are stepped through several phases,
// the extremes among them.
// ----------------------------------------------------------------------------
module relief_shade_pixel_tb;
  import rsp_pkg::*;

  typedef struct {
    logic [HW-1:0] center;
    logic [HW-1:0] east;
    logic [HW-1:0] south;
    logic          missing;
    logic          water;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } shade_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the registers, predicted colors in beat order.
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    logic [HW-1:0]   ocean_level;
    logic [CW-1:0]   light_gain;
    logic [3*CW-1:0] water_color;
    shade_t          shade_q[$];
    int unsigned     mismatches;

    function new();
      ocean_level = OCEAN_RST;
      light_gain  = LIGHT_RST;
      water_color = WATER_RST;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [3*CW-1:0] value);
      case (idx)
        REG_OCEAN: ocean_level = value[HW-1:0];
        REG_LIGHT: light_gain  = value[CW-1:0];
        REG_WATER: water_color = value;
        default: ;
      endcase
    endfunction

    // exact rational shading, truncated toward zero, clamped to 0..255
    function logic [CW-1:0] shade_channel(logic [CW-1:0] c, longint delta, longint denom);
      longint prod;
      longint num;
      longint q;
      prod = delta * longint'(light_gain);
      if (delta >= 0)
        num = longint'(c) * (denom - prod);
      else
        num = longint'(c) * denom + prod * longint'(255 - int'(c));
      q = num / denom;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[CW-1:0];
    endfunction

    function void note_pixel(pixel_t px);
      logic [CW-1:0] r;
      logic [CW-1:0] g;
      logic [CW-1:0] b;
      longint        delta;
      longint        denom;
      shade_t        want;
      if (px.water) begin
        r = water_color[23:16];
        g = water_color[15:8];
        b = water_color[7:0];
      end else begin
        r = px.red;
        g = px.green;
        b = px.blue;
      end
      if (px.missing) begin
        want.red   = r;
        want.green = g;
        want.blue  = b;
      end else begin
        delta = longint'(px.east) + longint'(px.south) - 2 * longint'(px.center);
        denom = (px.center < ocean_level) ? 65535 * 3 : 65535;
        want.red   = shade_channel(r, delta, denom);
        want.green = shade_channel(g, delta, denom);
        want.blue  = shade_channel(b, delta, denom);
      end
      shade_q.push_back(want);
    endfunction

    function void compare_channel(string field, logic [CW-1:0] want, logic [CW-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(shade_t got);
      shade_t want;
      if (shade_q.size() == 0) begin
        $error("result beat with no pixel pending: r=%0d g=%0d b=%0d",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = shade_q.pop_front();
      compare_channel("out_red", want.red, got.red);
      compare_channel("out_green", want.green, got.green);
      compare_channel("out_blue", want.blue, got.blue);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input known from time zero.
  // --------------------------------------------------------------------------
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [HW-1:0]   in_center_height = '0;
  logic [HW-1:0]   in_east_height = '0;
  logic [HW-1:0]   in_lower_height = '0;
  logic            in_neighbor_missing = 1'b0;
  logic            in_is_water = 1'b0;
  logic [CW-1:0]   in_base_red = '0;
  logic [CW-1:0]   in_base_green = '0;
  logic [CW-1:0]   in_base_blue = '0;
  logic            out_valid;
  logic [CW-1:0]   out_red;
  logic [CW-1:0]   out_green;
  logic [CW-1:0]   out_blue;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [3*CW-1:0] cfg_wdata = '0;

  pixel_scoreboard sb;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  relief_shade_pixel u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_center_height    (in_center_height),
    .in_east_height      (in_east_height),
    .in_lower_height     (in_lower_height),
    .in_neighbor_missing (in_neighbor_missing),
    .in_is_water         (in_is_water),
    .in_base_red         (in_base_red),
    .in_base_green       (in_base_green),
    .in_base_blue        (in_base_blue),
    .out_valid           (out_valid),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitor. All drives are nonblocking at the edge, so values read here are
  // the ones the DUT saw at this same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t px;
    shade_t got;
    if (rst_n && start && !busy) begin
      px.center  = in_center_height;
      px.east    = in_east_height;
      px.south   = in_lower_height;
      px.missing = in_neighbor_missing;
      px.water   = in_is_water;
      px.red     = in_base_red;
      px.green   = in_base_green;
      px.blue    = in_base_blue;
      sb.note_pixel(px);
    end
    // result strobe lasts one cycle; no backpressure, so take it right here
    if (rst_n && out_valid === 1'b1) begin
      got.red   = out_red;
      got.green = out_green;
      got.blue  = out_blue;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pixel_t make_px(int c, int e, int s, bit m, bit w,
                                     int r, int g, int b);
    pixel_t px;
    px.center  = c[HW-1:0];
    px.east    = e[HW-1:0];
    px.south   = s[HW-1:0];
    px.missing = m;
    px.water   = w;
    px.red     = r[CW-1:0];
    px.green   = g[CW-1:0];
    px.blue    = b[CW-1:0];
    return px;
  endfunction

  // neighbor height: rails, gentle slope around the center, or anything
  function automatic int pick_neighbor(int c);
    int off;
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 65535;
      2, 3, 4, 5: begin
        // magnitude spread over many octaves so the factor lands near 1 too
        off = $urandom_range(0, 1 << $urandom_range(0, 12));
        v = $urandom_range(0, 1) ? c + off : c - off;
      end
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic int pick_channel();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic pixel_t random_px();
    int c;
    case ($urandom_range(0, 9))
      0: c = 0;
      1: c = 65535;
      2, 3: begin
        // straddle the ocean threshold (divide-by-three switch)
        c = int'(sb.ocean_level) + $urandom_range(0, 2) - 1;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
      end
      default: c = $urandom_range(0, 65535);
    endcase
    return make_px(c, pick_neighbor(c), pick_neighbor(c),
                   $urandom_range(0, 6) == 0, $urandom_range(0, 3) == 0,
                   pick_channel(), pick_channel(), pick_channel());
  endfunction

  // mostly back to back or short, now and then a long pause
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_fields(pixel_t px);
    in_center_height    <= px.center;
    in_east_height      <= px.east;
    in_lower_height     <= px.south;
    in_neighbor_missing <= px.missing;
    in_is_water         <= px.water;
    in_base_red         <= px.red;
    in_base_green       <= px.green;
    in_base_blue        <= px.blue;
  endtask

  // Present one beat and return at the edge that took it; start stays high so
  // the next beat can follow with no bubble.
  task automatic send_pixel(pixel_t px);
    start <= 1'b1;
    put_fields(px);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // idle cycles with junk on the data lines, which must be ignored
  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      put_fields(random_px());
      repeat (n) @(posedge clk);
    end
  endtask

  // all three registers, one per edge, only with the pipe empty
  task automatic configure(logic [HW-1:0] ocean, logic [CW-1:0] light,
                           logic [3*CW-1:0] water);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OCEAN;
    cfg_wdata <= {8'd0, ocean};
    sb.write_reg(REG_OCEAN, {8'd0, ocean});
    @(posedge clk);
    cfg_index <= REG_LIGHT;
    cfg_wdata <= {16'd0, light};
    sb.write_reg(REG_LIGHT, {16'd0, light});
    @(posedge clk);
    cfg_index <= REG_WATER;
    cfg_wdata <= water;
    sb.write_reg(REG_WATER, water);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.shade_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pixel_t          directed_px[$];
    logic [HW-1:0]   ocean;
    logic [CW-1:0]   light;
    logic [3*CW-1:0] water;
    int              p;
    int              i;
    int              w;

    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset register values
    directed_px.push_back(make_px(0, 0, 0, 0, 0, 0, 0, 0));               // flat
    directed_px.push_back(make_px(65535, 65535, 65535, 0, 0, 255, 255, 255));
    directed_px.push_back(make_px(0, 65535, 65535, 0, 0, 128, 64, 200));  // steep up
    directed_px.push_back(make_px(65535, 0, 0, 0, 0, 10, 128, 250));      // steep down
    directed_px.push_back(make_px(19659, 19759, 19759, 0, 0, 200, 100, 50)); // below ocean
    directed_px.push_back(make_px(19660, 19760, 19760, 0, 0, 200, 100, 50)); // at ocean
    directed_px.push_back(make_px(19660, 19560, 19560, 0, 0, 200, 100, 50));
    directed_px.push_back(make_px(19659, 19559, 19559, 0, 0, 200, 100, 50));
    directed_px.push_back(make_px(0, 65535, 65535, 1, 0, 1, 2, 3));       // missing
    directed_px.push_back(make_px(1000, 1100, 1000, 0, 1, 7, 7, 7));      // water, shaded
    directed_px.push_back(make_px(1000, 1100, 1000, 1, 1, 7, 7, 7));      // water, missing
    directed_px.push_back(make_px(1000, 900, 1000, 0, 1, 0, 0, 0));
    directed_px.push_back(make_px(30000, 30500, 29500, 0, 0, 90, 180, 33)); // delta zero
    // factor just above one: channel dips a hair below zero
    directed_px.push_back(make_px(40000, 40437, 40437, 0, 0, 255, 128, 1));
    directed_px.push_back(make_px(40000, 40436, 40436, 0, 0, 255, 128, 1));
    directed_px.push_back(make_px(40000, 39563, 39563, 0, 0, 0, 128, 254));
    directed_px.push_back(make_px(40000, 40010, 40000, 0, 0, 255, 255, 255));
    directed_px.push_back(make_px(40000, 39990, 40000, 0, 0, 0, 0, 0));
    directed_px.push_back(make_px(12345, 54321, 777, 1, 0, 170, 85, 255));
    directed_px.push_back(make_px(65535, 65535, 0, 0, 0, 60, 120, 240));
    foreach (directed_px[k]) begin
      send_pixel(directed_px[k]);
      idle_for(idle_gap());
    end
    start <= 1'b0;
    drain();

    // register phases: rails first, then mixed and random settings
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin ocean = 16'd0;     light = 8'd0;   water = 24'h000000; end
        1: begin ocean = 16'hFFFF;  light = 8'hFF;  water = 24'hFFFFFF; end
        2: begin ocean = OCEAN_RST; light = 8'hFF;  water = 24'h000000; end
        3: begin ocean = 16'hFFFF;  light = 8'd0;   water = 24'($urandom); end
        4: begin ocean = 16'd0;     light = 8'hFF;  water = 24'($urandom); end
        5: begin ocean = 16'h8000;  light = 8'd1;   water = 24'hA5A55A; end
        default: begin
          ocean = 16'($urandom);
          light = 8'($urandom);
          water = 24'($urandom);
        end
      endcase
      configure(ocean, light, water);
      for (i = 0; i < 170; i++) begin
        send_pixel(random_px());
        // every third block of 32 beats streams with no gaps at all
        if (((i / 32) % 3) != 0)
          idle_for(idle_gap());
      end
      start <= 1'b0;
      drain();
    end

    // bounded wait for stragglers, then an idle tail longer than the pipe depth
    for (w = 0; w < 200 && sb.shade_q.size() != 0; w++)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.shade_q.size() == 0)
      $display("relief_shade_pixel_tb: PASS");
    else
      $display("relief_shade_pixel_tb: FAIL");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("relief_shade_pixel_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rsp_pkg.sv
rtl/core/rsp_cfg_regs.sv
rtl/core/rsp_front.sv
rtl/core/rsp_chan.sv
rtl/core/relief_shade_pixel.sv
sim/relief_shade_pixel_tb.sv
